FILE: rtl/ssh_pkg.sv
// ssh_pkg: shared types, constants and mix functions for the sampled string hash
// no dependencies; used by ssh_core and sampled_string_hash_top
`timescale 1ns / 1ps

package ssh_pkg;

    localparam int SAMPLE_COUNT_DEF = 8;
    localparam int LENGTH_BITS_DEF  = 16;

    localparam int UNIT_W = 16;
    localparam int HASH_W = 32;

    localparam logic [HASH_W-1:0] GOLDEN_SEED      = 32'h9e37_79b9;
    localparam logic [HASH_W-1:0] ZERO_REPLACEMENT = 32'h8000_0000;

    typedef enum logic {
        OP_BEGIN = 1'b0,
        OP_UNIT  = 1'b1
    } op_t;

    // one input transaction after unpacking
    typedef struct packed {
        op_t               op;
        logic [UNIT_W-1:0] string_length;
        logic [UNIT_W-1:0] code_unit;
    } item_t;

    // one round: add shift-10, xor shift-6
    function automatic logic [HASH_W-1:0] mix_round(input logic [HASH_W-1:0] h);
        logic [HASH_W-1:0] a;
        a = h + (h << 10);
        return a ^ (a << 6);
    endfunction

    // final avalanche, zero mapped to the top bit
    function automatic logic [HASH_W-1:0] finish(input logic [HASH_W-1:0] h);
        logic [HASH_W-1:0] a;
        logic [HASH_W-1:0] b;
        logic [HASH_W-1:0] c;
        a = h + (h << 3);
        b = a ^ (a >> 11);
        c = b + (b << 15);
        return (c == '0) ? ZERO_REPLACEMENT : c;
    endfunction

endpackage

FILE: rtl/ssh_core.sv
// ssh_core: per-string state and the combinational hash step
// depends on ssh_pkg
`timescale 1ns / 1ps

module ssh_core
    import ssh_pkg::*;
#(
    parameter int SAMPLE_COUNT = SAMPLE_COUNT_DEF,
    parameter int LENGTH_BITS  = LENGTH_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  item_t             item,
    output logic              result_valid,
    output logic [HASH_W-1:0] result_hash
);

    // compare width covers both the length and twice the sample count
    localparam int CMP_W = ((LENGTH_BITS > 7) ? LENGTH_BITS : 7) + 1;

    logic [HASH_W-1:0]      hash_reg,   hash_next;
    logic [LENGTH_BITS-1:0] pos_reg,    pos_next;
    logic [LENGTH_BITS-1:0] explen_reg, explen_next;
    logic                   active_reg, active_next;

    logic [LENGTH_BITS-1:0] len;
    logic [HASH_W-1:0]      seed_hash;
    logic [HASH_W-1:0]      unit_hash;
    logic [LENGTH_BITS-1:0] pos_inc;
    logic [CMP_W-1:0]       explen_w;
    logic [CMP_W-1:0]       pos_w;
    logic [CMP_W-1:0]       suffix_start;
    logic                   sampled;
    logic                   unit_done;

    always_comb
    begin
        len       = LENGTH_BITS'(item.string_length);
        seed_hash = mix_round(GOLDEN_SEED + HASH_W'(len));

        explen_w = CMP_W'(explen_reg);
        pos_w    = CMP_W'(pos_reg);
        if (explen_w < CMP_W'(2 * SAMPLE_COUNT))
        begin
            suffix_start = CMP_W'(SAMPLE_COUNT);
        end
        else
        begin
            suffix_start = explen_w - CMP_W'(SAMPLE_COUNT);
        end
        sampled = (pos_w < CMP_W'(SAMPLE_COUNT)) || (pos_w >= suffix_start);

        unit_hash = sampled ? mix_round(hash_reg + HASH_W'(item.code_unit)) : hash_reg;
        pos_inc   = pos_reg + 1'b1;
        unit_done = (pos_inc == explen_reg);

        hash_next    = hash_reg;
        pos_next     = pos_reg;
        explen_next  = explen_reg;
        active_next  = active_reg;
        result_valid = 1'b0;
        result_hash  = finish((item.op == OP_BEGIN) ? seed_hash : unit_hash);

        if (step)
        begin
            case (item.op)
                OP_BEGIN:
                begin
                    hash_next    = seed_hash;
                    pos_next     = '0;
                    explen_next  = len;
                    active_next  = (len != '0);
                    result_valid = (len == '0);
                end
                default:
                begin
                    // units with no open string are dropped
                    if (active_reg)
                    begin
                        hash_next    = unit_hash;
                        pos_next     = pos_inc;
                        active_next  = !unit_done;
                        result_valid = unit_done;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg   <= '0;
            pos_reg    <= '0;
            explen_reg <= '0;
            active_reg <= 1'b0;
        end
        else
        begin
            hash_reg   <= hash_next;
            pos_reg    <= pos_next;
            explen_reg <= explen_next;
            active_reg <= active_next;
        end
    end

endmodule

FILE: rtl/sampled_string_hash_top.sv
// sampled_string_hash_top: stream wrapper with input and result registers
// depends on ssh_pkg and ssh_core
`timescale 1ns / 1ps

// Sampled one-at-a-time string hash. A begin transaction (tuser = 0) carries
// the string length and seeds the hash; each following unit transaction
// (tuser = 1) carries one 16-bit code unit. Only the first SAMPLE_COUNT units
// and the last SAMPLE_COUNT units of the string are mixed in. When the last
// unit arrives, or at once for an empty string, one result transaction with
// the 32-bit hash (never zero) leaves on the master side. Units with no open
// string produce nothing; a begin while a string is open drops that string.
// Throughput is one transaction per cycle. An input transaction is loaded into
// the input register when it is accepted; the hash step then loads its result
// into the result register, through a path of one mix round plus the final
// avalanche. Back-pressure on the master side stalls the hash step, which in
// turn holds the input register and drops s_axis_tready.
module sampled_string_hash_top
    import ssh_pkg::*;
#(
    parameter int SAMPLE_COUNT = SAMPLE_COUNT_DEF,
    parameter int LENGTH_BITS  = LENGTH_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] string_length, [31:16] code_unit
    input  logic        s_axis_tuser,   // [0] op: 0 begin, 1 code unit

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [31:0] hash_value
);

    // input register stage
    logic  in_valid_reg, in_valid_next;
    item_t in_item_reg,  in_item_next;

    // result register stage
    logic              out_valid_reg, out_valid_next;
    logic [HASH_W-1:0] out_hash_reg,  out_hash_next;

    logic              step;
    logic              s_fire;
    logic              result_valid;
    logic [HASH_W-1:0] result_hash;

    // the hash step runs when the input register is full and the result slot is free or being emptied
    assign step          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || step;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_hash_reg;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        in_item_next  = in_item_reg;
        if (s_fire)
        begin
            in_valid_next          = 1'b1;
            in_item_next.op        = op_t'(s_axis_tuser);
            in_item_next.string_length = s_axis_tdata[15:0];
            in_item_next.code_unit = s_axis_tdata[31:16];
        end
        else if (step)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        out_hash_next  = out_hash_reg;
        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (step && result_valid)
        begin
            out_valid_next = 1'b1;
            out_hash_next  = result_hash;
        end
    end

    ssh_core #(
        .SAMPLE_COUNT (SAMPLE_COUNT),
        .LENGTH_BITS  (LENGTH_BITS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .item         (in_item_reg),
        .result_valid (result_valid),
        .result_hash  (result_hash)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers carry no reset
    always_ff @(posedge clk)
    begin
        in_item_reg  <= in_item_next;
        out_hash_reg <= out_hash_next;
    end

endmodule
